FILE: rtl/core/csis_pkg.sv
// Shared types and opcode constants for the CPU subset instruction step unit.
package csis_pkg;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] imm_lo;
    logic [7:0] imm_hi;
    logic [7:0] mem_lo;
    logic [7:0] mem_hi;
  } req_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [2:0]  cycles;
    logic [7:0]  reg_a_out;
    logic [7:0]  reg_f_out;
    logic [15:0] reg_de_out;
    logic [15:0] reg_hl_out;
    logic [15:0] reg_sp_out;
    logic [15:0] read_addr;
    logic [1:0]  write_count;
    logic [15:0] write_addr;
    logic [15:0] write_data;
    logic        unsupported;
  } rsp_t;

  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_START_PC = 2'd0;
  localparam cfg_idx_t CFG_START_SP = 2'd1;
  localparam cfg_idx_t CFG_BC_VALUE = 2'd2;

  localparam logic [15:0] RESET_PC = 16'h0100;
  localparam logic [15:0] RESET_SP = 16'hFFFE;

  localparam logic [7:0] OP_JP     = 8'hC3;
  localparam logic [7:0] OP_JP_Z   = 8'hCA;
  localparam logic [7:0] OP_JP_C   = 8'hDA;
  localparam logic [7:0] OP_JR     = 8'h18;
  localparam logic [7:0] OP_LD_A_N = 8'h3E;
  localparam logic [7:0] OP_LD_NN_A = 8'hEA;
  localparam logic [7:0] OP_LDI_A_HL = 8'h2A;
  localparam logic [7:0] OP_LDD_A_HL = 8'h3A;
  localparam logic [7:0] OP_LDI_HL_A = 8'h22;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_INC_A  = 8'h3C;
  localparam logic [7:0] OP_ADD_N  = 8'hC6;
  localparam logic [7:0] OP_SUB_N  = 8'hD6;
  localparam logic [7:0] OP_CP_N   = 8'hFE;
  localparam logic [7:0] OP_RRA    = 8'h1F;
  localparam logic [7:0] OP_PUSH_BC = 8'hC5;
  localparam logic [7:0] OP_POP_DE = 8'hD1;
  localparam logic [7:0] OP_CALL   = 8'hCD;
  localparam logic [7:0] OP_RET    = 8'hC9;

  localparam int unsigned FLAG_Z_BIT = 7;
  localparam int unsigned FLAG_C_BIT = 4;

endpackage

FILE: rtl/core/csis_req_if.sv
// Request channel carrying one instruction and its fetched bytes.
interface csis_req_if;
  logic                valid;
  logic                ready;
  csis_pkg::req_t      data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/csis_rsp_if.sv
// Result channel carrying the outcome of one instruction.
interface csis_rsp_if;
  logic                valid;
  logic                ready;
  csis_pkg::rsp_t      data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/csis_cfg_if.sv
// Configuration write channel: register index and write data.
interface csis_cfg_if;
  logic                  valid;
  logic                  ready;
  csis_pkg::cfg_idx_t    index;
  logic [15:0]           wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/core/csis_in_stage.sv
// Input register that holds one accepted request until it executes.
module csis_in_stage (
  input  logic            clk,
  input  logic            rst,
  csis_req_if.sink        req,
  input  logic            advance,
  output logic            held_valid,
  output csis_pkg::req_t  held
);
  import csis_pkg::*;

  assign req.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req.ready) begin
      held_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      held <= req.data;
    end
  end
endmodule

FILE: rtl/core/csis_exec.sv
// Architectural registers and single-pass execute logic for one instruction.
module csis_exec (
  input  logic            clk,
  input  logic            rst,
  csis_cfg_if.sink        cfg,
  input  logic            step,
  input  csis_pkg::req_t  item,
  output csis_pkg::rsp_t  result
);
  import csis_pkg::*;

  logic [7:0]  acc;
  logic [7:0]  flags;
  logic [15:0] de;
  logic [15:0] hl;
  logic [15:0] sp;
  logic [15:0] pc;
  logic [15:0] bc;

  logic [15:0] nn;
  logic [15:0] mword;
  logic [15:0] pc_p1;
  logic [15:0] pc_p2;
  logic [15:0] pc_p3;
  logic [15:0] sp_dec;
  logic [15:0] sp_inc;
  logic [8:0]  add_sum;
  logic [4:0]  add_nib;
  logic [8:0]  sub_diff;
  logic [7:0]  sub_flags;
  logic [7:0]  inc_val;
  logic        taken_z;
  logic        taken_c;

  assign cfg.ready = 1'b1;

  assign nn       = {item.imm_hi, item.imm_lo};
  assign mword    = {item.mem_hi, item.mem_lo};
  assign pc_p1    = pc + 16'd1;
  assign pc_p2    = pc + 16'd2;
  assign pc_p3    = pc + 16'd3;
  assign sp_dec   = sp - 16'd2;
  assign sp_inc   = sp + 16'd2;
  assign add_sum  = {1'b0, acc} + {1'b0, item.imm_lo};
  assign add_nib  = {1'b0, acc[3:0]} + {1'b0, item.imm_lo[3:0]};
  assign sub_diff = {1'b0, acc} - {1'b0, item.imm_lo};
  assign inc_val  = acc + 8'd1;
  assign taken_z  = flags[FLAG_Z_BIT];
  assign taken_c  = flags[FLAG_C_BIT];
  assign sub_flags = {sub_diff[7:0] == 8'd0, 1'b1, acc[3:0] < item.imm_lo[3:0],
                      sub_diff[8], 4'b0000};

  always_comb begin
    result.next_pc     = pc;
    result.cycles      = 3'd0;
    result.reg_a_out   = acc;
    result.reg_f_out   = flags;
    result.reg_de_out  = de;
    result.reg_hl_out  = hl;
    result.reg_sp_out  = sp;
    result.read_addr   = 16'd0;
    result.write_count = 2'd0;
    result.write_addr  = 16'd0;
    result.write_data  = 16'd0;
    result.unsupported = 1'b0;
    unique case (item.cmd) inside
      OP_JP: begin
        result.next_pc = nn;
        result.cycles  = 3'd4;
      end
      OP_JP_Z: begin
        result.next_pc = taken_z ? nn : pc_p3;
        result.cycles  = taken_z ? 3'd4 : 3'd3;
      end
      OP_JP_C: begin
        result.next_pc = taken_c ? nn : pc_p3;
        result.cycles  = taken_c ? 3'd4 : 3'd3;
      end
      OP_JR: begin
        result.next_pc = pc_p2 + {{8{item.imm_lo[7]}}, item.imm_lo};
        result.cycles  = 3'd3;
      end
      OP_LD_A_N: begin
        result.reg_a_out = item.imm_lo;
        result.next_pc   = pc_p2;
        result.cycles    = 3'd2;
      end
      OP_LD_NN_A: begin
        result.write_count = 2'd1;
        result.write_addr  = nn;
        result.write_data  = {8'd0, acc};
        result.next_pc     = pc_p3;
        result.cycles      = 3'd4;
      end
      OP_LDI_A_HL, OP_LDD_A_HL: begin
        result.read_addr  = hl;
        result.reg_a_out  = item.mem_lo;
        result.reg_hl_out = (item.cmd == OP_LDI_A_HL) ? hl + 16'd1 : hl - 16'd1;
        result.next_pc    = pc_p1;
        result.cycles     = 3'd2;
      end
      OP_LDI_HL_A, OP_LDD_HL_A: begin
        result.write_count = 2'd1;
        result.write_addr  = hl;
        result.write_data  = {8'd0, acc};
        result.reg_hl_out  = (item.cmd == OP_LDI_HL_A) ? hl + 16'd1 : hl - 16'd1;
        result.next_pc     = pc_p1;
        result.cycles      = 3'd2;
      end
      OP_INC_A: begin
        result.reg_a_out = inc_val;
        result.reg_f_out = {inc_val == 8'd0, 1'b0, acc[3:0] == 4'hF,
                            flags[FLAG_C_BIT], 4'b0000};
        result.next_pc   = pc_p1;
        result.cycles    = 3'd1;
      end
      OP_ADD_N: begin
        result.reg_a_out = add_sum[7:0];
        result.reg_f_out = {add_sum[7:0] == 8'd0, 1'b0, add_nib[4], add_sum[8], 4'b0000};
        result.next_pc   = pc_p2;
        result.cycles    = 3'd2;
      end
      OP_SUB_N: begin
        result.reg_a_out = sub_diff[7:0];
        result.reg_f_out = sub_flags;
        result.next_pc   = pc_p2;
        result.cycles    = 3'd2;
      end
      OP_CP_N: begin
        result.reg_f_out = sub_flags;
        result.next_pc   = pc_p2;
        result.cycles    = 3'd2;
      end
      OP_RRA: begin
        result.reg_a_out = {flags[FLAG_C_BIT], acc[7:1]};
        result.reg_f_out = {3'b000, acc[0], 4'b0000};
        result.next_pc   = pc_p1;
        result.cycles    = 3'd1;
      end
      OP_PUSH_BC: begin
        result.reg_sp_out  = sp_dec;
        result.write_count = 2'd2;
        result.write_addr  = sp_dec;
        result.write_data  = bc;
        result.next_pc     = pc_p1;
        result.cycles      = 3'd4;
      end
      OP_POP_DE: begin
        result.read_addr  = sp;
        result.reg_de_out = mword;
        result.reg_sp_out = sp_inc;
        result.next_pc    = pc_p1;
        result.cycles     = 3'd3;
      end
      OP_CALL: begin
        result.reg_sp_out  = sp_dec;
        result.write_count = 2'd2;
        result.write_addr  = sp_dec;
        result.write_data  = pc_p3;
        result.next_pc     = nn;
        result.cycles      = 3'd6;
      end
      OP_RET: begin
        result.read_addr  = sp;
        result.reg_sp_out = sp_inc;
        result.next_pc    = mword;
        result.cycles     = 3'd4;
      end
      default: begin
        result.unsupported = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 8'd0;
      flags <= 8'd0;
      de    <= 16'd0;
      hl    <= 16'd0;
      sp    <= RESET_SP;
      pc    <= RESET_PC;
      bc    <= 16'd0;
    end else begin
      if (step) begin
        acc   <= result.reg_a_out;
        flags <= result.reg_f_out;
        de    <= result.reg_de_out;
        hl    <= result.reg_hl_out;
        sp    <= result.reg_sp_out;
        pc    <= result.next_pc;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_START_PC: pc <= cfg.wdata;
          CFG_START_SP: sp <= cfg.wdata;
          CFG_BC_VALUE: bc <= cfg.wdata;
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: rtl/core/csis_out_stage.sv
// Result register that holds one finished instruction until it is taken.
module csis_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            held_valid,
  input  csis_pkg::rsp_t  result,
  output logic            advance,
  csis_rsp_if.source      rsp
);
  import csis_pkg::*;

  assign advance = held_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (!rsp.valid || rsp.ready) begin
      rsp.valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.data <= result;
    end
  end
endmodule

FILE: rtl/core/cpu_subset_instruction_step_unit.sv
// Top level of the CPU subset instruction step unit.
// Executes one instruction of a small 8-bit CPU subset per request and returns one result:
// next PC, machine cycles, A/F/DE/HL/SP, the read address and any one- or two-byte memory write.
// A request is taken into an input register, executed in a single pass against the
// architectural registers, and loaded into a result register; while results are taken, a
// new request can be accepted every cycle and throughput is one instruction per cycle, set
// by the single execute pass between the two registers. Writing start_pc or start_sp loads
// PC or SP at once; configuration writes are always ready and are meant to arrive while idle.
module cpu_subset_instruction_step_unit (
  input  logic        clk,
  input  logic        rst,
  csis_req_if.sink    req,
  csis_rsp_if.source  rsp,
  csis_cfg_if.sink    cfg
);
  import csis_pkg::*;

  logic held_valid;
  req_t held;
  rsp_t result;
  logic advance;

  csis_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  csis_exec u_exec (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (held),
    .result (result)
  );

  csis_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .result     (result),
    .advance    (advance),
    .rsp        (rsp)
  );

`ifndef NO_ASSERTIONS
  a_unsup_quiet: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.unsupported) |->
      (rsp.data.cycles == 3'd0 && rsp.data.write_count == 2'd0))
    else $error("unsupported result reports cycles or a write");

  a_push_at_sp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.write_count == 2'd2) |->
      (rsp.data.write_addr == rsp.data.reg_sp_out))
    else $error("two-byte write not at the new stack pointer");

  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !advance) |=> held_valid)
    else $error("held request dropped without executing");

  a_wcount_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.data.write_count != 2'd3))
    else $error("write count out of range");
`endif
endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the CPU subset instruction step unit.
module testbench;
  import csis_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 64;

  logic clk;
  logic rst;

  csis_req_if req_ch ();
  csis_rsp_if rsp_ch ();
  csis_cfg_if cfg_ch ();

  cpu_subset_instruction_step_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // architectural state and configuration tracked alongside the block
  logic [15:0] start_pc;
  logic [15:0] start_sp;
  logic [15:0] bc_word;
  logic [7:0]  acc;
  logic [7:0]  flags;
  logic [15:0] de_word;
  logic [15:0] hl_word;
  logic [15:0] sp_word;
  logic [15:0] pc_word;

  req_t pending_instrs[$];
  rsp_t expected_results[$];

  logic [7:0]  op_table [0:18];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_armed;
  bit          hold_used;
  int unsigned hold_left;
  bit          req_fire;
  int unsigned errors;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[cpu_subset_instruction_step_unit] ERROR");
      $finish;
    end
  end

  function automatic rsp_t execute_instr(req_t rq);
    rsp_t        r;
    logic [15:0] nn;
    logic [15:0] mword;
    logic [8:0]  sum;
    logic [4:0]  nib;
    logic [7:0]  diff;
    logic        carry_in;
    nn    = {rq.imm_hi, rq.imm_lo};
    mword = {rq.mem_hi, rq.mem_lo};
    r = '0;
    r.next_pc = pc_word;
    case (rq.cmd)
      OP_JP: begin
        r.next_pc = nn;
        r.cycles  = 3'd4;
      end
      OP_JP_Z, OP_JP_C: begin
        if ((rq.cmd == OP_JP_Z) ? flags[FLAG_Z_BIT] : flags[FLAG_C_BIT]) begin
          r.next_pc = nn;
          r.cycles  = 3'd4;
        end else begin
          r.next_pc = pc_word + 16'd3;
          r.cycles  = 3'd3;
        end
      end
      OP_JR: begin
        r.next_pc = pc_word + 16'd2 + {{8{rq.imm_lo[7]}}, rq.imm_lo};
        r.cycles  = 3'd3;
      end
      OP_LD_A_N: begin
        acc       = rq.imm_lo;
        r.next_pc = pc_word + 16'd2;
        r.cycles  = 3'd2;
      end
      OP_LD_NN_A: begin
        r.write_count = 2'd1;
        r.write_addr  = nn;
        r.write_data  = {8'h00, acc};
        r.next_pc     = pc_word + 16'd3;
        r.cycles      = 3'd4;
      end
      OP_LDI_A_HL, OP_LDD_A_HL: begin
        r.read_addr = hl_word;
        acc         = rq.mem_lo;
        hl_word     = (rq.cmd == OP_LDI_A_HL) ? hl_word + 16'd1 : hl_word - 16'd1;
        r.next_pc   = pc_word + 16'd1;
        r.cycles    = 3'd2;
      end
      OP_LDI_HL_A, OP_LDD_HL_A: begin
        r.write_count = 2'd1;
        r.write_addr  = hl_word;
        r.write_data  = {8'h00, acc};
        hl_word       = (rq.cmd == OP_LDI_HL_A) ? hl_word + 16'd1 : hl_word - 16'd1;
        r.next_pc     = pc_word + 16'd1;
        r.cycles      = 3'd2;
      end
      OP_INC_A: begin
        flags     = {acc == 8'hFF, 1'b0, acc[3:0] == 4'hF, flags[FLAG_C_BIT], 4'h0};
        acc       = acc + 8'd1;
        r.next_pc = pc_word + 16'd1;
        r.cycles  = 3'd1;
      end
      OP_ADD_N: begin
        sum       = {1'b0, acc} + {1'b0, rq.imm_lo};
        nib       = {1'b0, acc[3:0]} + {1'b0, rq.imm_lo[3:0]};
        flags     = {sum[7:0] == 8'h00, 1'b0, nib[4], sum[8], 4'h0};
        acc       = sum[7:0];
        r.next_pc = pc_word + 16'd2;
        r.cycles  = 3'd2;
      end
      OP_SUB_N, OP_CP_N: begin
        diff  = acc - rq.imm_lo;
        flags = {diff == 8'h00, 1'b1, acc[3:0] < rq.imm_lo[3:0], acc < rq.imm_lo, 4'h0};
        if (rq.cmd == OP_SUB_N) acc = diff;
        r.next_pc = pc_word + 16'd2;
        r.cycles  = 3'd2;
      end
      OP_RRA: begin
        carry_in  = flags[FLAG_C_BIT];
        flags     = {3'b000, acc[0], 4'h0};
        acc       = {carry_in, acc[7:1]};
        r.next_pc = pc_word + 16'd1;
        r.cycles  = 3'd1;
      end
      OP_PUSH_BC: begin
        sp_word       = sp_word - 16'd2;
        r.write_count = 2'd2;
        r.write_addr  = sp_word;
        r.write_data  = bc_word;
        r.next_pc     = pc_word + 16'd1;
        r.cycles      = 3'd4;
      end
      OP_POP_DE: begin
        r.read_addr = sp_word;
        de_word     = mword;
        sp_word     = sp_word + 16'd2;
        r.next_pc   = pc_word + 16'd1;
        r.cycles    = 3'd3;
      end
      OP_CALL: begin
        sp_word       = sp_word - 16'd2;
        r.write_count = 2'd2;
        r.write_addr  = sp_word;
        r.write_data  = pc_word + 16'd3;
        r.next_pc     = nn;
        r.cycles      = 3'd6;
      end
      OP_RET: begin
        r.read_addr = sp_word;
        r.next_pc   = mword;
        sp_word     = sp_word + 16'd2;
        r.cycles    = 3'd4;
      end
      default: r.unsupported = 1'b1;
    endcase
    pc_word      = r.next_pc;
    r.reg_a_out  = acc;
    r.reg_f_out  = flags;
    r.reg_de_out = de_word;
    r.reg_hl_out = hl_word;
    r.reg_sp_out = sp_word;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // sample both channels; retire the result first, then predict the new request
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result expected none got next_pc %h", $time, got.next_pc);
        end else begin
          want = expected_results.pop_front();
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("cycles", 16'(want.cycles), 16'(got.cycles));
          check_field("reg_a_out", 16'(want.reg_a_out), 16'(got.reg_a_out));
          check_field("reg_f_out", 16'(want.reg_f_out), 16'(got.reg_f_out));
          check_field("reg_de_out", want.reg_de_out, got.reg_de_out);
          check_field("reg_hl_out", want.reg_hl_out, got.reg_hl_out);
          check_field("reg_sp_out", want.reg_sp_out, got.reg_sp_out);
          check_field("read_addr", want.read_addr, got.read_addr);
          check_field("write_count", 16'(want.write_count), 16'(got.write_count));
          check_field("write_addr", want.write_addr, got.write_addr);
          check_field("write_data", want.write_data, got.write_data);
          check_field("unsupported", 16'(want.unsupported), 16'(got.unsupported));
        end
      end
      if (req_ch.valid && req_ch.ready) expected_results.push_back(execute_instr(req_ch.data));
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= pending_instrs.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // hold off once for a long stretch so the block backs up into its input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_armed && !hold_used) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      hold_used    <= 1'b1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic push_instr(logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                            logic [7:0] mlo, logic [7:0] mhi);
    req_t rq;
    rq.cmd    = op;
    rq.imm_lo = lo;
    rq.imm_hi = hi;
    rq.mem_lo = mlo;
    rq.mem_hi = mhi;
    pending_instrs.push_back(rq);
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned added;
    int unsigned roll;
    logic [7:0]  x;
    added = 0;
    while (added < count) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        push_instr(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
        added += 1;
      end else if (roll < 25) begin
        // load, compare against a near value, then branch on the outcome
        x = rand_byte();
        push_instr(OP_LD_A_N, x, rand_byte(), rand_byte(), rand_byte());
        push_instr(roll[0] ? OP_CP_N : OP_SUB_N, x + 8'($urandom_range(2)) - 8'd1,
                   rand_byte(), rand_byte(), rand_byte());
        push_instr(roll[1] ? OP_JP_Z : OP_JP_C, rand_byte(), rand_byte(),
                   rand_byte(), rand_byte());
        added += 3;
      end else begin
        push_instr(op_table[5'($urandom_range(18))], rand_byte(), rand_byte(),
                   rand_byte(), rand_byte());
        added += 1;
      end
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_START_PC: begin
        start_pc = val;
        pc_word  = val;
      end
      CFG_START_SP: begin
        start_sp = val;
        sp_word  = val;
      end
      CFG_BC_VALUE: bc_word = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] pc_val, logic [15:0] sp_val, logic [15:0] bc_val);
    write_reg(CFG_START_PC, pc_val);
    write_reg(CFG_START_SP, sp_val);
    write_reg(CFG_BC_VALUE, bc_val);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_instrs.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned rcv_pct, int unsigned count);
    send_idle_pct = send_pct;
    stall_pct     = rcv_pct;
    queue_random(count);
    wait_drained();
  endtask

  initial begin
    op_table = '{OP_JP, OP_JP_Z, OP_JP_C, OP_JR, OP_LD_A_N, OP_LD_NN_A, OP_LDI_A_HL,
                 OP_LDD_A_HL, OP_LDI_HL_A, OP_LDD_HL_A, OP_INC_A, OP_ADD_N, OP_SUB_N,
                 OP_CP_N, OP_RRA, OP_PUSH_BC, OP_POP_DE, OP_CALL, OP_RET};
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    rsp_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_START_PC;
    cfg_ch.wdata  = 16'h0000;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_armed    = 1'b0;
    hold_used     = 1'b0;
    hold_left     = 0;
    req_fire      = 1'b0;
    errors        = 0;
    cycle_count   = 0;
    start_pc      = RESET_PC;
    start_sp      = RESET_SP;
    bc_word       = 16'h0000;
    acc           = 8'h00;
    flags         = 8'h00;
    de_word       = 16'h0000;
    hl_word       = 16'h0000;
    sp_word       = RESET_SP;
    pc_word       = RESET_PC;
    rst = 1'b1;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: unknown opcodes, flag corners, branches both ways, wrapping addresses
    push_instr(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_instr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_instr(OP_LD_A_N, 8'hFF, 8'h00, 8'h00, 8'h00);
    push_instr(OP_INC_A, 8'h00, 8'h00, 8'h00, 8'h00);
    push_instr(OP_JP_Z, 8'h00, 8'h20, 8'h00, 8'h00);
    push_instr(OP_JP_C, 8'h34, 8'h12, 8'h00, 8'h00);
    push_instr(OP_ADD_N, 8'hFF, 8'h00, 8'h00, 8'h00);
    push_instr(OP_ADD_N, 8'h01, 8'h00, 8'h00, 8'h00);
    push_instr(OP_JP_C, 8'hFF, 8'hFF, 8'h00, 8'h00);
    push_instr(OP_JR, 8'h7F, 8'h00, 8'h00, 8'h00);
    push_instr(OP_JR, 8'h80, 8'h00, 8'h00, 8'h00);
    push_instr(OP_JR, 8'hFE, 8'h00, 8'h00, 8'h00);
    push_instr(OP_CP_N, 8'h01, 8'h00, 8'h00, 8'h00);
    push_instr(OP_JP_Z, 8'h00, 8'h80, 8'h00, 8'h00);
    push_instr(OP_LD_A_N, 8'h01, 8'h00, 8'h00, 8'h00);
    push_instr(OP_RRA, 8'h00, 8'h00, 8'h00, 8'h00);
    push_instr(OP_RRA, 8'h00, 8'h00, 8'h00, 8'h00);
    push_instr(OP_SUB_N, 8'hC0, 8'h00, 8'h00, 8'h00);
    push_instr(OP_LD_NN_A, 8'hFF, 8'hFF, 8'h00, 8'h00);
    push_instr(OP_LDD_HL_A, 8'h00, 8'h00, 8'h00, 8'h00);
    push_instr(OP_LDI_A_HL, 8'h00, 8'h00, 8'hFF, 8'h00);
    push_instr(OP_LDI_HL_A, 8'h00, 8'h00, 8'h00, 8'h00);
    push_instr(OP_LDD_A_HL, 8'h00, 8'h00, 8'h00, 8'hFF);
    push_instr(OP_PUSH_BC, 8'h00, 8'h00, 8'h00, 8'h00);
    push_instr(OP_POP_DE, 8'h00, 8'h00, 8'h34, 8'h12);
    push_instr(OP_CALL, 8'h78, 8'h56, 8'h00, 8'h00);
    push_instr(OP_RET, 8'h00, 8'h00, 8'hFF, 8'hFF);
    wait_drained();

    write_all(16'h0000, 16'h0000, 16'hFFFF);
    hold_armed = 1'b1;
    run_phase(0, 0, 200);

    write_all(16'hFFFF, 16'hFFFF, 16'h0000);
    run_phase(53, 0, 200);

    write_all(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
              16'($urandom_range(16'hFFFF)));
    run_phase(0, 53, 200);

    write_all(16'hFFFE, 16'h0001, 16'hA55A);
    run_phase(8, 8, 200);

    write_all(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
              16'($urandom_range(16'hFFFF)));
    run_phase(0, 0, 125);

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[cpu_subset_instruction_step_unit] OK");
    end else begin
      $display("[cpu_subset_instruction_step_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/csis_pkg.sv
rtl/core/csis_req_if.sv
rtl/core/csis_rsp_if.sv
rtl/core/csis_cfg_if.sv
rtl/core/csis_in_stage.sv
rtl/core/csis_exec.sv
rtl/core/csis_out_stage.sv
rtl/core/cpu_subset_instruction_step_unit.sv
dv/testbench.sv
